// File: rtl/btr_pkg.sv
// ============================================================================
// btr_pkg: shared definitions of the bitmap text renderer
// Sizes, register indexes, character codes, interface structs and helpers.
// ============================================================================
package btr_pkg;

    // Design sizes.
    localparam int MAX_GLYPH_WIDTH  = 16;
    localparam int MAX_GLYPH_HEIGHT = 16;
    localparam int CHAR_COUNT       = 256;
    localparam int COORD_BITS       = 12;

    // Fixed widths of the item fields and the registers.
    localparam int ROW_PIXELS  = 16;
    localparam int OUT_COORD_W = 12;
    localparam int ADDR_BITS   = 24;
    localparam int CFG_W       = 13;
    localparam int DIM_BITS    = 5;
    localparam int CODE_BITS   = 8;
    localparam int COLOR_BITS  = 32;

    // Derived sizes.
    localparam int CUR_BITS   = COORD_BITS + 1;
    localparam int CHAR_BITS  = $clog2(CHAR_COUNT);
    localparam int FONT_DEPTH = CHAR_COUNT * MAX_GLYPH_HEIGHT;
    localparam int FONT_AW    = $clog2(FONT_DEPTH);
    localparam int GW_CAP     = (MAX_GLYPH_WIDTH < ROW_PIXELS) ? MAX_GLYPH_WIDTH : ROW_PIXELS;
    localparam int GH_CAP     = (MAX_GLYPH_HEIGHT < ROW_PIXELS) ? MAX_GLYPH_HEIGHT : ROW_PIXELS;
    localparam int SCREEN_CAP = 1 << COORD_BITS;

    // Output queue.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

    // Configuration port.
    localparam int PADDR_BITS   = 5;
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PITCH_WORDS   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_GLYPH_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_GLYPH_HEIGHT  = 3'd4;

    localparam logic [CFG_W-1:0]    RST_SCREEN_WIDTH  = 13'd1024;
    localparam logic [CFG_W-1:0]    RST_SCREEN_HEIGHT = 13'd768;
    localparam logic [CFG_W-1:0]    RST_PITCH_WORDS   = 13'd1024;
    localparam logic [DIM_BITS-1:0] RST_GLYPH_WIDTH   = 5'd8;
    localparam logic [DIM_BITS-1:0] RST_GLYPH_HEIGHT  = 5'd16;

    // Item codes.
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_RENDER = 1'b1;
    localparam logic [CODE_BITS-1:0] CODE_NL = 8'h0A;
    localparam logic [CODE_BITS-1:0] CODE_CR = 8'h0D;

    typedef struct packed {
        logic [CFG_W-1:0]    screen_width;
        logic [CFG_W-1:0]    screen_height;
        logic [CFG_W-1:0]    pitch_words;
        logic [DIM_BITS-1:0] glyph_width;
        logic [DIM_BITS-1:0] glyph_height;
    } t_cfg;

    typedef struct packed {
        logic [OUT_COORD_W-1:0] row_x;
        logic [OUT_COORD_W-1:0] row_y;
        logic [ADDR_BITS-1:0]   word_address;
        logic [ROW_PIXELS-1:0]  row_bits;
        logic [DIM_BITS-1:0]    visible_count;
        logic [COLOR_BITS-1:0]  fg_out;
        logic [COLOR_BITS-1:0]  bg_out;
        logic                   last_row;
    } t_row;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WRAP  = 4'b0010,
        S_CHECK = 4'b0100,
        S_ROWS  = 4'b1000
    } t_state;

    // Cursor add that sticks at the largest cursor value.
    function automatic logic [CUR_BITS-1:0] sat_add(input logic [CUR_BITS-1:0] a,
                                                     input logic [DIM_BITS-1:0] b);
        logic [CUR_BITS:0] s;
        s = {1'b0, a} + {{(CUR_BITS + 1 - DIM_BITS){1'b0}}, b};
        return s[CUR_BITS] ? {CUR_BITS{1'b1}} : s[CUR_BITS-1:0];
    endfunction

endpackage

// File: rtl/btr_cfg_regs.sv
// ============================================================================
// btr_cfg_regs: configuration register file
// APB-style write and read access to the five renderer registers.
// ============================================================================
module btr_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [btr_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output btr_pkg::t_cfg                  o_cfg
);
    import btr_pkg::*;

    t_cfg                    r_cfg;
    logic                    w_wr;
    logic [CFG_IDX_BITS-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[PADDR_BITS-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width  <= RST_SCREEN_WIDTH;
            r_cfg.screen_height <= RST_SCREEN_HEIGHT;
            r_cfg.pitch_words   <= RST_PITCH_WORDS;
            r_cfg.glyph_width   <= RST_GLYPH_WIDTH;
            r_cfg.glyph_height  <= RST_GLYPH_HEIGHT;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_SCREEN_WIDTH:  r_cfg.screen_width  <= pwdata[CFG_W-1:0];
                REG_SCREEN_HEIGHT: r_cfg.screen_height <= pwdata[CFG_W-1:0];
                REG_PITCH_WORDS:   r_cfg.pitch_words   <= pwdata[CFG_W-1:0];
                REG_GLYPH_WIDTH:   r_cfg.glyph_width   <= pwdata[DIM_BITS-1:0];
                REG_GLYPH_HEIGHT:  r_cfg.glyph_height  <= pwdata[DIM_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SCREEN_WIDTH:  prdata = 32'(r_cfg.screen_width);
            REG_SCREEN_HEIGHT: prdata = 32'(r_cfg.screen_height);
            REG_PITCH_WORDS:   prdata = 32'(r_cfg.pitch_words);
            REG_GLYPH_WIDTH:   prdata = 32'(r_cfg.glyph_width);
            REG_GLYPH_HEIGHT:  prdata = 32'(r_cfg.glyph_height);
            default:           prdata = 32'd0;
        endcase
    end

endmodule

// File: rtl/btr_font_store.sv
// ============================================================================
// btr_font_store: glyph row memory
// Synchronous memory of glyph row bitmaps, one write and one read port,
// read data registered.
// ============================================================================
module btr_font_store (
    input  logic                            i_clk,
    input  logic                            i_wr_en,
    input  logic [btr_pkg::FONT_AW-1:0]     i_wr_addr,
    input  logic [btr_pkg::ROW_PIXELS-1:0]  i_wr_data,
    input  logic                            i_rd_en,
    input  logic [btr_pkg::FONT_AW-1:0]     i_rd_addr,
    output logic [btr_pkg::ROW_PIXELS-1:0]  o_rd_data
);
    import btr_pkg::*;

    logic [ROW_PIXELS-1:0] r_mem [FONT_DEPTH];
    logic [ROW_PIXELS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/btr_out_fifo.sv
// ============================================================================
// btr_out_fifo: result queue
// Small queue of finished glyph rows that decouples the row pipeline from
// the downstream consumer.
// ============================================================================
module btr_out_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  btr_pkg::t_row                i_push_data,
    input  logic                         i_pop_ready,
    output logic                         o_valid,
    output btr_pkg::t_row                o_data,
    output logic [btr_pkg::OUT_CW-1:0]   o_count
);
    import btr_pkg::*;

    t_row              r_mem [OUT_DEPTH];
    logic [OUT_PW-1:0] r_wr_ptr;
    logic [OUT_PW-1:0] r_rd_ptr;
    logic [OUT_CW-1:0] r_count;
    logic              w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign w_pop   = o_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OUT_PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + OUT_PW'(1);
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + OUT_CW'(1);
            end else if (!i_push && w_pop) begin
                r_count <= r_count - OUT_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// File: rtl/bitmap_text_renderer_core.sv
// ============================================================================
// bitmap_text_renderer_core: bitmap font text renderer
// A load writes the font store in its transfer cycle. A drawing render
// runs the cursor steps, then one font store read a cycle for the gh rows
// in use (1..16), held while the result queue has no room; each row is
// registered in stage one and then queued. A render that draws nothing
// ends in a cursor step. Reset is synchronous: cursor, present flags and
// registers return to defaults; the font store holds garbage until loaded.
// ============================================================================
module bitmap_text_renderer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    // Input item channel.
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_action,
    input  logic [7:0]                     i_char_code,
    input  logic [3:0]                     i_load_row,
    input  logic [15:0]                    i_load_bits,
    input  logic                           i_load_present,
    input  logic                           i_string_start,
    input  logic [11:0]                    i_start_x,
    input  logic [11:0]                    i_start_y,
    input  logic [31:0]                    i_fg_color,
    input  logic [31:0]                    i_bg_color,

    // Result row channel.
    output logic                           o_row_valid,
    input  logic                           i_row_ready,
    output logic [11:0]                    o_row_x,
    output logic [11:0]                    o_row_y,
    output logic [23:0]                    o_word_address,
    output logic [15:0]                    o_row_bits,
    output logic [4:0]                     o_visible_count,
    output logic [31:0]                    o_fg_out,
    output logic [31:0]                    o_bg_out,
    output logic                           o_last_row,

    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [btr_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import btr_pkg::*;

    // ------------------------------------------------------------------
    // Configuration and derived sizes. Glyph sizes are clamped to what a
    // row word and the font store can hold; the screen is clamped to the
    // coordinate range.
    // ------------------------------------------------------------------
    t_cfg                w_cfg;
    logic [DIM_BITS-1:0] w_gw;
    logic [DIM_BITS-1:0] w_gh;
    logic [CUR_BITS-1:0] w_sw;
    logic [CUR_BITS-1:0] w_sh;
    logic                w_zero;

    btr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_gw = (32'(w_cfg.glyph_width) > GW_CAP) ? DIM_BITS'(GW_CAP) : w_cfg.glyph_width;
    assign w_gh = (32'(w_cfg.glyph_height) > GH_CAP) ? DIM_BITS'(GH_CAP) : w_cfg.glyph_height;
    assign w_sw = (32'(w_cfg.screen_width) > SCREEN_CAP) ? CUR_BITS'(SCREEN_CAP)
                                                         : CUR_BITS'(w_cfg.screen_width);
    assign w_sh = (32'(w_cfg.screen_height) > SCREEN_CAP) ? CUR_BITS'(SCREEN_CAP)
                                                          : CUR_BITS'(w_cfg.screen_height);
    assign w_zero = (w_gw == '0) || (w_gh == '0);

    // ------------------------------------------------------------------
    // Control state and the captured render item.
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    logic [CUR_BITS-1:0] r_cx, n_cx;
    logic [CUR_BITS-1:0] r_cy, n_cy;
    logic [COORD_BITS-1:0] r_org, n_org;
    logic                r_done, n_done;
    logic [DIM_BITS-1:0] r_row, n_row;
    logic [CUR_BITS-1:0] r_row_y, n_row_y;
    logic [DIM_BITS-1:0] r_vis, n_vis;
    logic [CHAR_COUNT-1:0] r_gvalid;
    logic                r_present;
    logic                r_s1_valid;

    logic [CODE_BITS-1:0]   r_in_code;
    logic                   r_in_sstart;
    logic [11:0]            r_in_sx;
    logic [11:0]            r_in_sy;
    logic [COLOR_BITS-1:0]  r_in_fg;
    logic [COLOR_BITS-1:0]  r_in_bg;

    logic w_in_fire;
    assign o_ready   = (r_state == S_IDLE);
    assign w_in_fire = i_valid && o_ready;

    // ------------------------------------------------------------------
    // Font store. Loads write in the cycle of their transfer; rows are read
    // only while drawing, so a write and a read never meet on one entry.
    // ------------------------------------------------------------------
    logic                  w_font_we;
    logic [FONT_AW-1:0]    w_font_waddr;
    logic [FONT_AW-1:0]    w_font_raddr;
    logic [ROW_PIXELS-1:0] w_font_rdata;
    logic                  w_issue;
    logic                  w_load_char_ok;

    assign w_load_char_ok = 32'(i_char_code) < CHAR_COUNT;
    assign w_font_we   = w_in_fire && (i_action == ACT_LOAD) && w_load_char_ok
                         && (32'(i_load_row) < MAX_GLYPH_HEIGHT);
    assign w_font_waddr = FONT_AW'(32'(i_char_code) * MAX_GLYPH_HEIGHT + 32'(i_load_row));
    assign w_font_raddr = FONT_AW'(32'(r_in_code) * MAX_GLYPH_HEIGHT + 32'(r_row));

    btr_font_store u_font (
        .i_clk     (i_clk),
        .i_wr_en   (w_font_we),
        .i_wr_addr (w_font_waddr),
        .i_wr_data (i_load_bits),
        .i_rd_en   (w_issue),
        .i_rd_addr (w_font_raddr),
        .o_rd_data (w_font_rdata)
    );

    // ------------------------------------------------------------------
    // Cursor evaluation. The first step applies a string start, handles
    // newline and carriage return, and wraps at the right edge. The second
    // step checks the bottom edge and decides whether the glyph is drawn.
    // The present flag of the captured character is registered during the
    // first step; no load can slip in while a render is being evaluated.
    // ------------------------------------------------------------------
    logic [CUR_BITS-1:0]   w_e_cx;
    logic [CUR_BITS-1:0]   w_e_cy;
    logic [COORD_BITS-1:0] w_e_org;
    logic                  w_e_done;
    logic                  w_wrap;
    logic                  w_bottom;
    logic                  w_present;
    logic                  w_draw;
    logic [CUR_BITS-1:0]   w_room;
    logic [DIM_BITS-1:0]   w_vis_calc;
    logic                  w_row_last;
    logic                  w_can_issue;
    logic [OUT_CW-1:0]     w_fifo_count;

    assign w_e_cx   = r_in_sstart ? CUR_BITS'(r_in_sx) : r_cx;
    assign w_e_cy   = r_in_sstart ? CUR_BITS'(r_in_sy) : r_cy;
    assign w_e_org  = r_in_sstart ? COORD_BITS'(r_in_sx) : r_org;
    assign w_e_done = r_in_sstart ? 1'b0 : r_done;

    assign w_wrap   = ({1'b0, w_e_cx} + (CUR_BITS + 1)'(w_gw)) > {1'b0, w_sw};
    assign w_bottom = ({1'b0, r_cy} + (CUR_BITS + 1)'(w_gh)) > {1'b0, w_sh};

    assign w_present = (32'(r_in_code) < CHAR_COUNT) && r_present;
    assign w_draw    = w_present && (r_cx < w_sw);
    assign w_room    = w_sw - r_cx;
    assign w_vis_calc = (w_room < CUR_BITS'(w_gw)) ? DIM_BITS'(w_room) : w_gw;

    // A row is started only when the result queue is sure to have space
    // for it, counting the row already on its way through the pipeline.
    assign w_row_last  = (r_row + DIM_BITS'(1)) == w_gh;
    assign w_can_issue = (32'(w_fifo_count) + 32'(r_s1_valid)) < OUT_DEPTH;

    always_comb begin
        n_state = r_state;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_org   = r_org;
        n_done  = r_done;
        n_row   = r_row;
        n_row_y = r_row_y;
        n_vis   = r_vis;
        w_issue = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire && (i_action == ACT_RENDER)) begin
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                n_cx    = w_e_cx;
                n_cy    = w_e_cy;
                n_org   = w_e_org;
                n_done  = w_e_done;
                n_state = S_IDLE;
                // With no string open or a zero glyph size only the string
                // start takes effect.
                if (!w_e_done && !w_zero) begin
                    priority if (r_in_code == CODE_NL) begin
                        n_cx = CUR_BITS'(w_e_org);
                        n_cy = sat_add(w_e_cy, w_gh);
                    end else if (r_in_code == CODE_CR) begin
                        n_cx = CUR_BITS'(w_e_org);
                    end else begin
                        n_state = S_CHECK;
                        if (w_wrap) begin
                            n_cx = CUR_BITS'(w_e_org);
                            n_cy = sat_add(w_e_cy, w_gh);
                        end
                    end
                end
            end
            S_CHECK: begin
                priority if (w_bottom) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (w_draw) begin
                    n_vis   = w_vis_calc;
                    n_row   = '0;
                    n_row_y = r_cy;
                    n_state = S_ROWS;
                end else begin
                    n_cx    = sat_add(r_cx, w_gw);
                    n_state = S_IDLE;
                end
            end
            S_ROWS: begin
                if (w_can_issue) begin
                    w_issue = 1'b1;
                    n_row   = r_row + DIM_BITS'(1);
                    n_row_y = r_row_y + CUR_BITS'(1);
                    if (w_row_last) begin
                        n_cx    = sat_add(r_cx, w_gw);
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cx     <= '0;
            r_cy     <= '0;
            r_org    <= '0;
            r_done   <= 1'b1;
            r_gvalid <= '0;
        end else begin
            r_state <= n_state;
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_org   <= n_org;
            r_done  <= n_done;
            if (w_in_fire && (i_action == ACT_LOAD) && w_load_char_ok) begin
                r_gvalid[i_char_code[CHAR_BITS-1:0]] <= i_load_present;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row     <= n_row;
        r_row_y   <= n_row_y;
        r_vis     <= n_vis;
        r_present <= r_gvalid[r_in_code[CHAR_BITS-1:0]];
        if (w_in_fire && (i_action == ACT_RENDER)) begin
            r_in_code   <= i_char_code;
            r_in_sstart <= i_string_start;
            r_in_sx     <= i_start_x;
            r_in_sy     <= i_start_y;
            r_in_fg     <= i_fg_color;
            r_in_bg     <= i_bg_color;
        end
    end

    // ------------------------------------------------------------------
    // Row pipeline. Stage one holds the line times pitch product while the
    // font store reads the row; stage two adds the column, clips the bits
    // and pushes the finished row into the result queue. The column is
    // carried along because the cursor moves on at the last row.
    // ------------------------------------------------------------------
    logic [CUR_BITS+CFG_W-1:0] w_prod;
    logic [ADDR_BITS-1:0]      r_s1_prod;
    logic [COORD_BITS-1:0]     r_s1_x;
    logic [COORD_BITS-1:0]     r_s1_y;
    logic                      r_s1_last;
    logic [ROW_PIXELS-1:0]     w_mask;
    t_row                      w_push_row;
    t_row                      w_out_row;

    assign w_prod = (CUR_BITS + CFG_W)'(r_row_y) * (CUR_BITS + CFG_W)'(w_cfg.pitch_words);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s1_prod <= w_prod[ADDR_BITS-1:0];
            r_s1_x    <= r_cx[COORD_BITS-1:0];
            r_s1_y    <= r_row_y[COORD_BITS-1:0];
            r_s1_last <= w_row_last;
        end
    end

    // Keep the leftmost visible pixels, clear the rest.
    assign w_mask = ~({ROW_PIXELS{1'b1}} >> r_vis);

    always_comb begin
        w_push_row.row_x         = OUT_COORD_W'(r_s1_x);
        w_push_row.row_y         = OUT_COORD_W'(r_s1_y);
        w_push_row.word_address  = r_s1_prod + ADDR_BITS'(r_s1_x);
        w_push_row.row_bits      = w_font_rdata & w_mask;
        w_push_row.visible_count = r_vis;
        w_push_row.fg_out        = r_in_fg;
        w_push_row.bg_out        = r_in_bg;
        w_push_row.last_row      = r_s1_last;
    end

    btr_out_fifo u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1_valid),
        .i_push_data (w_push_row),
        .i_pop_ready (i_row_ready),
        .o_valid     (o_row_valid),
        .o_data      (w_out_row),
        .o_count     (w_fifo_count)
    );

    assign o_row_x         = w_out_row.row_x;
    assign o_row_y         = w_out_row.row_y;
    assign o_word_address  = w_out_row.word_address;
    assign o_row_bits      = w_out_row.row_bits;
    assign o_visible_count = w_out_row.visible_count;
    assign o_fg_out        = w_out_row.fg_out;
    assign o_bg_out        = w_out_row.bg_out;
    assign o_last_row      = w_out_row.last_row;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_queue_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(w_fifo_count) + 32'(r_s1_valid)) <= OUT_DEPTH)
        else $error("row queue credit exceeded");

    a_stage_from_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $past(r_state == S_ROWS))
        else $error("pipeline row without a drawing cycle");

    a_rows_open_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROWS) |-> !r_done)
        else $error("drawing rows of a finished string");

    a_visible_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_row_valid |-> (o_visible_count != '0))
        else $error("result row with no visible pixels");

endmodule

// File: verif/btr_row_checker.sv
// ============================================================================
// btr_row_checker: glyph row predictor and comparator
// Watches the item, row and register channels of the text renderer. Each
// accepted item updates a private copy of the font store and text cursor and
// queues the glyph rows it should produce. Each accepted row is compared
// field by field with the oldest queued row.
// ============================================================================
module btr_row_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_valid,
    input  logic                           i_ready,
    input  logic                           i_action,
    input  logic [7:0]                     i_char_code,
    input  logic [3:0]                     i_load_row,
    input  logic [15:0]                    i_load_bits,
    input  logic                           i_load_present,
    input  logic                           i_string_start,
    input  logic [11:0]                    i_start_x,
    input  logic [11:0]                    i_start_y,
    input  logic [31:0]                    i_fg_color,
    input  logic [31:0]                    i_bg_color,

    input  logic                           i_row_valid,
    input  logic                           i_row_ready,
    input  logic [11:0]                    i_row_x,
    input  logic [11:0]                    i_row_y,
    input  logic [23:0]                    i_word_address,
    input  logic [15:0]                    i_row_bits,
    input  logic [4:0]                     i_visible_count,
    input  logic [31:0]                    i_fg_out,
    input  logic [31:0]                    i_bg_out,
    input  logic                           i_last_row,

    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [btr_pkg::PADDR_BITS-1:0] i_paddr,
    input  logic [31:0]                    i_pwdata,
    input  logic                           i_pready,

    output int                             o_fail_count,
    output int                             o_rows_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import btr_pkg::*;

    localparam int CURSOR_LIMIT = (1 << CUR_BITS) - 1;

    logic [ROW_PIXELS-1:0] font_store [FONT_DEPTH];
    logic                  glyph_present [CHAR_COUNT];
    int                    pen_x;
    int                    pen_y;
    int                    line_origin;
    logic                  string_closed;
    t_cfg                  cfg;
    t_row                  expected_rows [$];

    function automatic int cursor_add(input int a, input int b);
        return (a + b > CURSOR_LIMIT) ? CURSOR_LIMIT : a + b;
    endfunction

    task automatic check_field(input string field, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, exp_val, act_val);
            o_fail_count++;
        end
    endtask

    // Applies one accepted item and queues the glyph rows it draws.
    task automatic predict_rows();
        int                    gw;
        int                    gh;
        int                    sw;
        int                    sh;
        int                    vis;
        int                    r;
        int                    base;
        logic [ROW_PIXELS-1:0] mask;
        t_row                  row;

        base = int'(i_char_code) * MAX_GLYPH_HEIGHT;
        if (i_action == ACT_LOAD) begin
            glyph_present[i_char_code] = i_load_present;
            font_store[base + int'(i_load_row)] = i_load_bits;
            return;
        end

        if (i_string_start) begin
            pen_x         = int'(i_start_x);
            pen_y         = int'(i_start_y);
            line_origin   = int'(i_start_x);
            string_closed = 1'b0;
        end
        if (string_closed) return;

        gw = (int'(cfg.glyph_width) > GW_CAP) ? GW_CAP : int'(cfg.glyph_width);
        gh = (int'(cfg.glyph_height) > GH_CAP) ? GH_CAP : int'(cfg.glyph_height);
        if (gw == 0 || gh == 0) return;
        sw = (int'(cfg.screen_width) > SCREEN_CAP) ? SCREEN_CAP : int'(cfg.screen_width);
        sh = (int'(cfg.screen_height) > SCREEN_CAP) ? SCREEN_CAP : int'(cfg.screen_height);

        if (i_char_code == CODE_NL) begin
            pen_x = line_origin;
            pen_y = cursor_add(pen_y, gh);
            return;
        end
        if (i_char_code == CODE_CR) begin
            pen_x = line_origin;
            return;
        end

        // Wrap before drawing, then close the string at the bottom edge.
        if (pen_x + gw > sw) begin
            pen_x = line_origin;
            pen_y = cursor_add(pen_y, gh);
        end
        if (pen_y + gh > sh) begin
            string_closed = 1'b1;
            return;
        end

        if (glyph_present[i_char_code] && pen_x < sw) begin
            vis  = (sw - pen_x < gw) ? sw - pen_x : gw;
            mask = {ROW_PIXELS{1'b1}};
            mask = mask << (ROW_PIXELS - vis);
            for (r = 0; r < gh; r++) begin
                row.row_x         = OUT_COORD_W'(pen_x);
                row.row_y         = OUT_COORD_W'(pen_y + r);
                row.word_address  = ADDR_BITS'((pen_y + r) * int'(cfg.pitch_words) + pen_x);
                row.row_bits      = font_store[base + r] & mask;
                row.visible_count = DIM_BITS'(vis);
                row.fg_out        = i_fg_color;
                row.bg_out        = i_bg_color;
                row.last_row      = (r == gh - 1);
                expected_rows.push_back(row);
            end
        end
        pen_x = cursor_add(pen_x, gw);
    endtask

    always @(posedge i_clk) begin
        t_row exp_row;
        int   idx;
        if (!i_rst_n) begin
            for (idx = 0; idx < CHAR_COUNT; idx++) glyph_present[idx] = 1'b0;
            pen_x             = 0;
            pen_y             = 0;
            line_origin       = 0;
            string_closed     = 1'b1;
            cfg.screen_width  = RST_SCREEN_WIDTH;
            cfg.screen_height = RST_SCREEN_HEIGHT;
            cfg.pitch_words   = RST_PITCH_WORDS;
            cfg.glyph_width   = RST_GLYPH_WIDTH;
            cfg.glyph_height  = RST_GLYPH_HEIGHT;
            expected_rows.delete();
            o_fail_count      = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[PADDR_BITS-1:2])
                    REG_SCREEN_WIDTH:  cfg.screen_width  = i_pwdata[CFG_W-1:0];
                    REG_SCREEN_HEIGHT: cfg.screen_height = i_pwdata[CFG_W-1:0];
                    REG_PITCH_WORDS:   cfg.pitch_words   = i_pwdata[CFG_W-1:0];
                    REG_GLYPH_WIDTH:   cfg.glyph_width   = i_pwdata[DIM_BITS-1:0];
                    REG_GLYPH_HEIGHT:  cfg.glyph_height  = i_pwdata[DIM_BITS-1:0];
                    default: ;
                endcase
            end

            // Rows on the output belong to older items, so compare first.
            if (i_row_valid && i_row_ready) begin
                if (expected_rows.size() == 0) begin
                    $error("glyph row transfer with no row expected (x 0x%0h, y 0x%0h)",
                           i_row_x, i_row_y);
                    o_fail_count++;
                end else begin
                    exp_row = expected_rows.pop_front();
                    check_field("row_x", 32'(exp_row.row_x), 32'(i_row_x));
                    check_field("row_y", 32'(exp_row.row_y), 32'(i_row_y));
                    check_field("word_address", 32'(exp_row.word_address),
                                32'(i_word_address));
                    check_field("row_bits", 32'(exp_row.row_bits), 32'(i_row_bits));
                    check_field("visible_count", 32'(exp_row.visible_count),
                                32'(i_visible_count));
                    check_field("fg_out", exp_row.fg_out, i_fg_out);
                    check_field("bg_out", exp_row.bg_out, i_bg_out);
                    check_field("last_row", 32'(exp_row.last_row), 32'(i_last_row));
                end
            end

            if (i_valid && i_ready) predict_rows();
        end
        o_rows_pending = expected_rows.size();
    end

endmodule

// File: verif/tb_bitmap_text_renderer_core.sv
// ============================================================================
// tb_bitmap_text_renderer_core: testbench of the bitmap text renderer
// Preloads a set of glyphs, runs directed cursor and clipping cases, then
// random strings under several screen and glyph settings; both channels
// stall at random save in the last ones. The row checker predicts and compares.
// ============================================================================
module tb_bitmap_text_renderer_core;
    timeunit 1ns;
    timeprecision 1ps;
    import btr_pkg::*;

    localparam real CLK_PERIOD    = 10.0;
    localparam int  RESET_CYCLES  = 6;
    localparam int  DRAIN_LIMIT   = 20000;
    // Lets any item still in flight that produces no rows finish.
    localparam int  TAIL_CYCLES   = 24;
    localparam int  RUN_LIMIT_NS  = 5_000_000;
    localparam int  POOL_SIZE     = 4;
    localparam int  COORD_MAX     = (1 << OUT_COORD_W) - 1;

    // One item of the input channel.
    typedef struct {
        logic        action;
        logic [7:0]  char_code;
        logic [3:0]  load_row;
        logic [15:0] load_bits;
        logic        load_present;
        logic        string_start;
        logic [11:0] start_x;
        logic [11:0] start_y;
        logic [31:0] fg_color;
        logic [31:0] bg_color;
    } t_text_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_action;
    logic [7:0]            i_char_code;
    logic [3:0]            i_load_row;
    logic [15:0]           i_load_bits;
    logic                  i_load_present;
    logic                  i_string_start;
    logic [11:0]           i_start_x;
    logic [11:0]           i_start_y;
    logic [31:0]           i_fg_color;
    logic [31:0]           i_bg_color;
    logic                  o_row_valid;
    logic                  i_row_ready;
    logic [11:0]           o_row_x;
    logic [11:0]           o_row_y;
    logic [23:0]           o_word_address;
    logic [15:0]           o_row_bits;
    logic [4:0]            o_visible_count;
    logic [31:0]           o_fg_out;
    logic [31:0]           o_bg_out;
    logic                  o_last_row;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int fail_count;
    int rows_pending;

    // Idle rates in percent for the item sender and the row receiver.
    int send_idle_pct;
    int recv_idle_pct;

    // Shadow of the current register setting, used to aim start positions.
    int cfg_sw;
    int cfg_sh;
    int cfg_gw;

    // Rows written per character since reset. A character is only marked
    // present once all of its rows hold data, so no render ever reads an
    // unwritten font row.
    logic [15:0] loaded_rows [CHAR_COUNT];

    bitmap_text_renderer_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_char_code     (i_char_code),
        .i_load_row      (i_load_row),
        .i_load_bits     (i_load_bits),
        .i_load_present  (i_load_present),
        .i_string_start  (i_string_start),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_fg_color      (i_fg_color),
        .i_bg_color      (i_bg_color),
        .o_row_valid     (o_row_valid),
        .i_row_ready     (i_row_ready),
        .o_row_x         (o_row_x),
        .o_row_y         (o_row_y),
        .o_word_address  (o_word_address),
        .o_row_bits      (o_row_bits),
        .o_visible_count (o_visible_count),
        .o_fg_out        (o_fg_out),
        .o_bg_out        (o_bg_out),
        .o_last_row      (o_last_row),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    btr_row_checker u_row_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_ready         (o_ready),
        .i_action        (i_action),
        .i_char_code     (i_char_code),
        .i_load_row      (i_load_row),
        .i_load_bits     (i_load_bits),
        .i_load_present  (i_load_present),
        .i_string_start  (i_string_start),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_fg_color      (i_fg_color),
        .i_bg_color      (i_bg_color),
        .i_row_valid     (o_row_valid),
        .i_row_ready     (i_row_ready),
        .i_row_x         (o_row_x),
        .i_row_y         (o_row_y),
        .i_word_address  (o_word_address),
        .i_row_bits      (o_row_bits),
        .i_visible_count (o_visible_count),
        .i_fg_out        (o_fg_out),
        .i_bg_out        (o_bg_out),
        .i_last_row      (o_last_row),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_fail_count    (fail_count),
        .o_rows_pending  (rows_pending)
    );

    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    // The row receiver decides once per cycle, at the falling edge, whether
    // it takes a row at the next rising edge.
    always @(negedge i_clk) begin
        i_row_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Characters that get a full glyph during preload. The last one ends up
    // without its present flag, so it exercises the no-glyph path.
    function automatic logic [7:0] pool_code(input int idx);
        case (idx)
            0:       return 8'h00;
            1:       return 8'h41;
            2:       return 8'hFF;
            default: return 8'h43;
        endcase
    endfunction

    function automatic logic [7:0] pick_code();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return pool_code($urandom_range(0, POOL_SIZE - 1));
        if (roll < 70) return CODE_NL;
        if (roll < 77) return CODE_CR;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    // Presents one item and holds it until the transfer. Valid is only
    // lowered by an idle cycle or by the caller, never in the step that
    // raises it again.
    task automatic send_item(input t_text_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_action       <= it.action;
        i_char_code    <= it.char_code;
        i_load_row     <= it.load_row;
        i_load_bits    <= it.load_bits;
        i_load_present <= it.load_present;
        i_string_start <= it.string_start;
        i_start_x      <= it.start_x;
        i_start_y      <= it.start_y;
        i_fg_color     <= it.fg_color;
        i_bg_color     <= it.bg_color;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Loads one font row. The fields a load ignores carry random values.
    task automatic load_font_row(input logic [7:0] code, input logic [3:0] row,
                                 input logic [15:0] bits, input logic present);
        t_text_item  it;
        logic [15:0] written;
        written           = loaded_rows[code] | (16'h1 << row);
        loaded_rows[code] = written;
        it.action         = ACT_LOAD;
        it.char_code      = code;
        it.load_row       = row;
        it.load_bits      = bits;
        it.load_present   = present && (written == 16'hFFFF);
        it.string_start   = 1'($urandom_range(0, 1));
        it.start_x        = 12'($urandom_range(0, COORD_MAX));
        it.start_y        = 12'($urandom_range(0, COORD_MAX));
        it.fg_color       = $urandom;
        it.bg_color       = $urandom;
        send_item(it);
    endtask

    // Renders one character. Start coordinates only matter on a string
    // start; otherwise they are random.
    task automatic render_char(input logic [7:0] code, input logic sstart,
                               input int sx, input int sy);
        t_text_item it;
        it.action       = ACT_RENDER;
        it.char_code    = code;
        it.load_row     = 4'($urandom_range(0, 15));
        it.load_bits    = 16'($urandom);
        it.load_present = 1'($urandom_range(0, 1));
        it.string_start = sstart;
        it.start_x      = sstart ? 12'(sx) : 12'($urandom_range(0, COORD_MAX));
        it.start_y      = sstart ? 12'(sy) : 12'($urandom_range(0, COORD_MAX));
        it.fg_color     = $urandom;
        it.bg_color     = $urandom;
        send_item(it);
    endtask

    // Fills all rows of one glyph. Solid and empty glyphs make clipping easy
    // to see; the rest get random bitmaps.
    task automatic preload_glyph(input logic [7:0] code, input logic present);
        int r;
        for (r = 0; r < MAX_GLYPH_HEIGHT; r++) begin
            load_font_row(code, 4'(r),
                          (code == 8'hFF) ? 16'hFFFF :
                          (code == 8'h00) ? 16'h0000 : 16'($urandom),
                          present);
        end
    endtask

    // Waits until every expected row has been transferred and then lets
    // any item without rows finish inside the block.
    task automatic drain();
        int waited;
        waited  = 0;
        i_valid <= 1'b0;
        while (rows_pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    // One register write: setup cycle, access cycle, then it idles so that
    // the next write starts in a step of its own.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Writes every register. Only called while the block is idle.
    task automatic configure(input int sw, input int sh, input int pitch,
                             input int gw, input int gh);
        write_reg(REG_SCREEN_WIDTH, 32'(sw));
        write_reg(REG_SCREEN_HEIGHT, 32'(sh));
        write_reg(REG_PITCH_WORDS, 32'(pitch));
        write_reg(REG_GLYPH_WIDTH, 32'(gw));
        write_reg(REG_GLYPH_HEIGHT, 32'(gh));
        cfg_sw = (sw > SCREEN_CAP) ? SCREEN_CAP : sw;
        cfg_sh = (sh > SCREEN_CAP) ? SCREEN_CAP : sh;
        cfg_gw = (gw > GW_CAP) ? GW_CAP : gw;
    endtask

    // Hand-picked cases on a 64 x 48 screen with 8 x 8 glyphs.
    task automatic run_directed();
        // No string is open after reset, so these are ignored.
        render_char(8'h41, 1'b0, 0, 0);
        render_char(CODE_NL, 1'b0, 0, 0);
        // A string at the top left: a glyph, a NUL glyph, a glyph without its
        // present flag, and a character that was never loaded.
        render_char(8'h41, 1'b1, 0, 0);
        render_char(8'h00, 1'b0, 0, 0);
        render_char(8'h43, 1'b0, 0, 0);
        render_char(8'h01, 1'b0, 0, 0);
        // Carriage return draws over the first glyph; newline moves down.
        render_char(CODE_CR, 1'b0, 0, 0);
        render_char(8'hFF, 1'b0, 0, 0);
        render_char(CODE_NL, 1'b0, 0, 0);
        render_char(8'h41, 1'b0, 0, 0);
        // Near the right edge the glyph wraps back to its own origin and is
        // still clipped to four pixels.
        render_char(8'hFF, 1'b1, 60, 8);
        render_char(8'h41, 1'b0, 0, 0);
        // An origin on the right edge draws nothing but moves on.
        render_char(8'h41, 1'b1, 64, 0);
        // The bottom line still fits; the next line ends the string.
        render_char(8'h41, 1'b1, 0, 40);
        render_char(CODE_NL, 1'b0, 0, 0);
        render_char(8'h41, 1'b0, 0, 0);
        render_char(8'h41, 1'b0, 0, 0);
        render_char(CODE_NL, 1'b0, 0, 0);
        // A newline that opens a string, then a glyph flush with the edge.
        render_char(CODE_NL, 1'b1, 56, 0);
        render_char(8'hFF, 1'b0, 0, 0);
        // The largest start position ends the string at once.
        render_char(8'h41, 1'b1, COORD_MAX, COORD_MAX);
        // Present flag set late, then cleared and set again.
        load_font_row(8'h43, 4'd15, 16'hA5C3, 1'b1);
        render_char(8'h43, 1'b1, 16, 16);
        load_font_row(8'h41, 4'd7, 16'h8001, 1'b0);
        render_char(8'h41, 1'b0, 0, 0);
        load_font_row(8'h41, 4'd3, 16'h7FFE, 1'b1);
    endtask

    // Random strings: each opens at a start position aimed at the current
    // screen and continues with random characters, with font loads mixed in.
    task automatic run_random_strings(input int n_renders);
        int done_renders;
        int str_len;
        int roll;
        int sx;
        int sy;
        int k;
        done_renders = 0;
        while (done_renders < n_renders) begin
            str_len = $urandom_range(1, 4);
            roll    = $urandom_range(0, 99);
            if (roll < 70) begin
                sx = $urandom_range(0, clamp_coord(cfg_sw - 1));
                sy = $urandom_range(0, clamp_coord(cfg_sh / 2));
            end else if (roll < 85) begin
                sx = clamp_coord(cfg_sw - int'($urandom_range(0, cfg_gw + 1)));
                sy = $urandom_range(0, clamp_coord(cfg_sh - 1));
            end else begin
                sx = $urandom_range(0, COORD_MAX);
                sy = $urandom_range(0, COORD_MAX);
            end
            render_char(pick_code(), 1'b1, sx, sy);
            done_renders++;
            for (k = 1; k < str_len; k++) begin
                if ($urandom_range(0, 99) < 12) begin
                    load_font_row(($urandom_range(0, 99) < 70) ?
                                      pool_code($urandom_range(0, POOL_SIZE - 1)) :
                                      8'($urandom_range(0, 255)),
                                  4'($urandom_range(0, 15)), 16'($urandom),
                                  ($urandom_range(0, 99) < 75));
                end
                render_char(pick_code(), 1'b0, 0, 0);
                done_renders++;
            end
        end
    endtask

    initial begin
        int c;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_action       = ACT_LOAD;
        i_char_code    = '0;
        i_load_row     = '0;
        i_load_bits    = '0;
        i_load_present = 1'b0;
        i_string_start = 1'b0;
        i_start_x      = '0;
        i_start_y      = '0;
        i_fg_color     = '0;
        i_bg_color     = '0;
        i_row_ready    = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 21;
        recv_idle_pct  = 73;
        cfg_sw         = RST_SCREEN_WIDTH;
        cfg_sh         = RST_SCREEN_HEIGHT;
        cfg_gw         = RST_GLYPH_WIDTH;
        for (c = 0; c < CHAR_COUNT; c++) loaded_rows[c] = '0;

        // Reset is held once and released at a falling edge.
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Full glyphs for the pool.
        for (c = 0; c < POOL_SIZE; c++) preload_glyph(pool_code(c), pool_code(c) != 8'h43);

        // Sender idles rarely, receiver often.
        drain();
        configure(64, 48, 100, 8, 8);
        run_directed();
        run_random_strings(3);
        drain();
        configure(4096, 4096, 4096, 16, 16);
        run_random_strings(3);

        // Sender idles often, receiver rarely.
        send_idle_pct = 73;
        recv_idle_pct = 21;
        drain();
        configure(1, 1, 1, 1, 1);
        run_random_strings(3);
        drain();
        configure(200, 100, 333, 13, 7);
        run_random_strings(3);

        // No idling. Oversized registers saturate, zero glyph sizes ignore
        // every character and a zero screen ends every string.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        drain();
        configure(8191, 5000, 8191, 31, 17);
        run_random_strings(3);
        drain();
        configure(100, 60, 50, 0, 8);
        run_random_strings(2);
        drain();
        configure(100, 60, 50, 8, 0);
        run_random_strings(2);
        drain();
        configure(0, 0, 1, 4, 4);
        run_random_strings(2);
        drain();
        configure(RST_SCREEN_WIDTH, RST_SCREEN_HEIGHT, RST_PITCH_WORDS,
                  RST_GLYPH_WIDTH, RST_GLYPH_HEIGHT);
        run_random_strings(3);
        drain();

        if (rows_pending != 0) begin
            $error("%0d expected glyph rows never transferred", rows_pending);
        end
        if (fail_count == 0 && rows_pending == 0) begin
            $display("** bitmap_text_renderer_core: PASSED **");
        end else begin
            $display("** bitmap_text_renderer_core: FAILED **");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(RUN_LIMIT_NS);
        $display("** bitmap_text_renderer_core: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
rtl/btr_pkg.sv
rtl/btr_cfg_regs.sv
rtl/btr_font_store.sv
rtl/btr_out_fifo.sv
rtl/bitmap_text_renderer_core.sv
verif/btr_row_checker.sv
verif/tb_bitmap_text_renderer_core.sv
